// File: design/assert_macros.svh
// assertion macros shared by the sorted priority queue rtl
// no dependencies; included inside module bodies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies

package spq_pkg;

   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;
   localparam int DEPTH_DEF = 16;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [OCC_W-1:0]          occ_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // per-cell control from the queue controller
   typedef struct packed {
      logic ins;       // insert transfer this cycle, queue not full
      logic pop;       // pop transfer this cycle, queue not empty
      logic left_lt;   // left neighbor holds a value below the new one; tied high at the front cell
      logic occupied;  // this cell holds a stored value
   } cell_ctl_type;

endpackage

// File: design/spq_cell.sv
// one storage cell of the sorted priority queue chain
// depends on spq_pkg

module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::value_type   ins_value,
   input  spq_pkg::value_type   left_value,
   input  spq_pkg::value_type   right_value,
   output spq_pkg::value_type   entry_ff,
   output logic                 lt
);
   import spq_pkg::*;

   value_type entry_in;

   // stored value strictly below the incoming one: stays in place on insert
   assign lt = ctl.occupied && (entry_ff < ins_value);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && !lt) begin
         entry_in = ctl.left_lt ? ins_value : left_value;
      end else if (ctl.pop) begin
         entry_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/sorted_priority_queue_unit.sv
// top level of the sorted priority queue: cell chain plus count and response
// depends on spq_pkg, spq_cell and assert_macros.svh
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_opcode, req_value                   start high, busy low
//   response  rsp_front_value, rsp_status,            rsp_valid strobe, one cycle
//             rsp_occupancy
//
// all cells compare against the new value in parallel and shift left or right
// together, so busy never rises and a new transfer is taken on every
// clock edge
// the response appears in the cycle after the request transfer
// reset clears the count and the response strobe; cell contents are not reset
// the receiver cannot stall, so nothing waits on the response side

module sorted_priority_queue_unit #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  spq_pkg::value_type  req_value,
   output logic                rsp_valid,
   output spq_pkg::value_type  rsp_front_value,
   output spq_pkg::status_type rsp_status,
   output spq_pkg::occ_type    rsp_occupancy
);
   import spq_pkg::*;
   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   value_type        front_ff, front_in;
   status_type       status_ff, status_in;

   logic             accept;
   logic             full, empty;
   logic             ins_go, pop_go;

   value_type        cell_value [DEPTH];
   logic             cell_lt    [DEPTH];
   cell_ctl_type     cell_ctl   [DEPTH];

   // the cell chain never stalls a request: always ready
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign ins_go = accept && (req_opcode == OP_INSERT) && !full;
   assign pop_go = accept && (req_opcode == OP_POP) && !empty;

   // chain of cells; cell 0 is the front (smallest)
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_value;
      value_type right_value;
      logic      left_lt;

      if (i == 0) begin : g_first
         assign left_value = req_value;
         assign left_lt    = 1'b1;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      assign cell_ctl[i].ins      = ins_go;
      assign cell_ctl[i].pop      = pop_go;
      assign cell_ctl[i].left_lt  = left_lt;
      assign cell_ctl[i].occupied = (CNT_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .ins_value   (req_value),
         .left_value  (left_value),
         .right_value (right_value),
         .entry_ff    (cell_value[i]),
         .lt          (cell_lt[i])
      );
   end

   // count and response fields
   always_comb begin
      count_in  = count_ff;
      front_in  = '0;
      status_in = STATUS_OK;
      if (ins_go) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_go) begin
         count_in = count_ff - CNT_W'(1);
         front_in = cell_value[0];
      end else if (accept && (req_opcode == OP_POP)) begin
         status_in = STATUS_EMPTY;
      end else if (accept) begin
         status_in = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // response payload, qualified by the strobe
   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff  <= front_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_status      = status_ff;
   assign rsp_occupancy   = OCC_W'(count_ff);

   // count never passes capacity
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count over depth")
   // every request transfer gives a response in the next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid, "missing response")
   // an empty-pop report always comes with an empty queue
   `ASSERT_IMPLIES(a_empty_occ, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), count_ff == '0, "empty status with stored values")
   // front two entries stay in order
   `ASSERT_IMPLIES(a_front_sorted, clock, reset, count_ff > CNT_W'(1), cell_value[0] <= cell_value[1], "front entries out of order")

endmodule

// File: verif/spq_checker.sv
// response checker for the sorted priority queue: shadow queue plus in-order compare
// depends on spq_pkg

module spq_checker #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_opcode,
   input  spq_pkg::value_type  req_value,
   input  logic                rsp_valid,
   input  spq_pkg::value_type  rsp_front_value,
   input  spq_pkg::status_type rsp_status,
   input  spq_pkg::occ_type    rsp_occupancy,
   output int                  fail_count,
   output int                  pending_count
);
   import spq_pkg::*;

   typedef struct packed {
      value_type  front_value;
      status_type status;
      occ_type    occupancy;
   } response_type;

   value_type    shadow_entries [DEPTH];
   int           shadow_count;
   response_type expected_responses [$];

   // applies one operation to the shadow queue and returns its response
   task automatic predict_response(input logic op, input value_type val,
                                   output response_type resp);
      int pos;
      resp = '0;
      resp.status = STATUS_OK;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            resp.status = STATUS_FULL;
         end else begin
            // new value goes ahead of the first entry not below it
            pos = 0;
            while (pos < shadow_count && shadow_entries[pos] < val)
               pos++;
            for (int i = shadow_count; i > pos; i--)
               shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos] = val;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            resp.status = STATUS_EMPTY;
         end else begin
            resp.front_value = shadow_entries[0];
            for (int i = 1; i < shadow_count; i++)
               shadow_entries[i-1] = shadow_entries[i];
            shadow_count--;
         end
      end
      resp.occupancy = occ_type'(shadow_count);
   endtask

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         shadow_count = 0;
         expected_responses.delete();
         fail_count = 0;
      end else begin
         if (start && !busy) begin
            predict_response(req_opcode, req_value, want);
            expected_responses.push_back(want);
         end
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_front_value !== want.front_value) begin
                  $error("rsp_front_value: expected %0d, got %0d",
                         want.front_value, rsp_front_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("rsp_occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_occupancy);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_responses.size();
   end

endmodule

// File: verif/testbench.sv
// top of the sorted priority queue testbench: clock, reset, request stimulus, verdict
// depends on spq_pkg, sorted_priority_queue_unit and spq_checker

module testbench;
   import spq_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int WATCHDOG_LIMIT = 400;   // well above the longest idle gap that pick_gap returns

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_opcode;
   value_type  req_value;
   logic       rsp_valid;
   value_type  rsp_front_value;
   status_type rsp_status;
   occ_type    rsp_occupancy;
   int         fail_count;
   int         pending_count;
   int         idle_cycles;

   sorted_priority_queue_unit #(.DEPTH(DEPTH)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy)
   );

   // watches both channels, predicts and compares
   spq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog: ends the run after too many cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request transfer, then an optional idle gap
   // called at a rising edge; returns at the edge that ends the gap
   task automatic send_item(input logic op, input value_type val, input int gap);
      req_opcode <= op;
      req_value  <= val;
      start      <= 1'b1;
      @(posedge clock);
      // busy read here still holds the value sampled at this edge
      while (busy) @(posedge clock);
      if (gap > 0) begin
         // drop start and put junk on the payload while idle
         start      <= 1'b0;
         req_opcode <= 1'($urandom);
         req_value  <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly no gap, otherwise short gaps or a few long ones; none at all when no_gaps is set
   function automatic int pick_gap(input bit no_gaps);
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // full-range values, narrow clusters for duplicates and the extremes
   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return $urandom;
         4, 5:       return value_type'($urandom_range(0, 8)) - 4;
         6:          return 32'h8000_0000 + $urandom_range(0, 3);
         default:    return 32'h7fff_ffff - $urandom_range(0, 3);
      endcase
   endfunction

   initial begin
      int   issued;
      int   phase_len;
      int   insert_pct;
      bit   no_gaps;
      logic op;

      reset      = 1'b1;
      start      = 1'b0;
      req_opcode = OP_INSERT;
      req_value  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: pop on empty, extremes, duplicates, drain back to empty
      send_item(OP_POP,    32'hffff_ffff, 0);
      send_item(OP_INSERT, 32'h7fff_ffff, 1);
      send_item(OP_INSERT, 32'h8000_0000, 0);
      send_item(OP_INSERT, 32'h0000_0000, 0);
      send_item(OP_INSERT, 32'hffff_ffff, 2);
      send_item(OP_INSERT, 32'h0000_0001, 0);
      send_item(OP_INSERT, 32'h0000_0000, 0);
      send_item(OP_INSERT, 32'h8000_0000, 0);
      send_item(OP_INSERT, 32'h7fff_ffff, 0);
      send_item(OP_POP,    32'h5555_5555, 0);
      send_item(OP_POP,    32'haaaa_aaaa, 1);
      send_item(OP_INSERT, 32'h8000_0000, 0);
      repeat (8) send_item(OP_POP, $urandom, 0);
      send_item(OP_POP,    32'h0000_0000, 0);
      send_item(OP_POP,    32'h8000_0000, 3);

      // random: phases that lean toward filling, draining or neither, so the
      // queue runs into both the full and the empty boundary many times
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
            send_item(op, pick_value(), pick_gap(no_gaps));
            issued++;
         end
      end
      // final item always leaves a gap so start is low from here on
      send_item(OP_POP, $urandom, 1);

      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// File: sorted_priority_queue_unit.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_unit.sv
verif/spq_checker.sv
verif/testbench.sv
